/* rtl/mvfe_pkg.sv */
// Shared definitions for the multivalue field extractor: delimiter codes,
// register indexes, selector and count types, and selector helper functions.
// No dependencies.
package mvfe_pkg;

   // Default maximum record length in bytes
   localparam int unsigned MaxRecordBytesDefault = 65535;

   // Delimiter bytes, highest level first
   localparam logic [7:0] MARK_FIELD = 8'h1E;
   localparam logic [7:0] MARK_VALUE = 8'h1D;
   localparam logic [7:0] MARK_SUB   = 8'h1C;

   // Saturation value for starts, lengths and counts
   localparam logic [15:0] SAT16 = 16'hFFFF;

   // Configuration register indexes
   localparam int          CsrIndexW           = 2;
   localparam logic [1:0]  CSR_FIELD_SELECT    = 2'd0;
   localparam logic [1:0]  CSR_VALUE_SELECT    = 2'd1;
   localparam logic [1:0]  CSR_SUBVALUE_SELECT = 2'd2;

   // Selection level codes
   localparam logic [1:0] LEVEL_FIELD = 2'd1;
   localparam logic [1:0] LEVEL_VALUE = 2'd2;
   localparam logic [1:0] LEVEL_SUB   = 2'd3;

   typedef struct packed {
      logic signed [15:0] field;
      logic signed [15:0] value;
      logic signed [15:0] subvalue;
   } select_type;

   typedef struct packed {
      logic [15:0] field;
      logic [15:0] value;
      logic [15:0] subvalue;
   } count_type;

   // Deepest level that has a nonzero selector
   function automatic logic [1:0] select_level(select_type s);
      logic [1:0] lvl;
      if (s.subvalue != 16'sd0) begin
         lvl = LEVEL_SUB;
      end else if (s.value != 16'sd0) begin
         lvl = LEVEL_VALUE;
      end else begin
         lvl = LEVEL_FIELD;
      end
      return lvl;
   endfunction

   function automatic logic select_negative(select_type s);
      return s.field[15] | s.value[15] | s.subvalue[15];
   endfunction

   function automatic logic select_whole(select_type s);
      return (s.field == 16'sd0) && (s.value == 16'sd0) && (s.subvalue == 16'sd0);
   endfunction

   // True when the byte closes a part at the selected level
   function automatic logic ends_segment(logic [7:0] b, logic [1:0] lvl);
      return (b == MARK_FIELD) ||
             ((b == MARK_VALUE) && (lvl != LEVEL_FIELD)) ||
             ((b == MARK_SUB) && (lvl == LEVEL_SUB));
   endfunction

endpackage

/* rtl/multivalue_field_extract.sv */
// Multivalue field extractor: one record byte per request, result at record end.
// Depends on mvfe_pkg and mvfe_match.
//
// Takes a record one byte per request, split by field (0x1E), value (0x1D) and
// subvalue (0x1C) marks, and at the record's last byte (or an empty-record
// request) returns the start offset and length of the part picked by the three
// selector registers. A zero selector below the deepest nonzero one takes the
// whole part; a zero above it stands for 1. Any negative selector or an absent
// part gives start 0, length 0. One request is taken every cycle while the
// request side is not stalled; a request passes the input register, the update
// logic and the result register before its result is offered. The request side
// stalls only while a record end sits in the input register behind a stalled
// result. Bytes at or beyond MAX_RECORD_BYTES are dropped and set record_too_long,
// as does any start, length or count saturating at 65535. The user must write
// selectors through the csr port only while no record is in flight (unenforced).
module multivalue_field_extract #(
   parameter int unsigned MAX_RECORD_BYTES = mvfe_pkg::MaxRecordBytesDefault
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [7:0]                     req_data_byte,
   input  logic                           req_last_byte,
   input  logic                           req_empty_record,
   // result channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [15:0]                    rsp_match_start,
   output logic [15:0]                    rsp_match_length,
   output logic                           rsp_record_too_long,
   // configuration
   input  logic                           csr_write_enable,
   input  logic [mvfe_pkg::CsrIndexW-1:0] csr_index,
   input  logic [15:0]                    csr_write_data
);
   import mvfe_pkg::*;

   localparam int unsigned    PosW     = $clog2(MAX_RECORD_BYTES + 1);
   localparam logic [PosW-1:0] PosLimit = PosW'(MAX_RECORD_BYTES);

   // Saturate a byte position to 16 bits; bit 16 flags saturation
   function automatic logic [16:0] clip_pos(logic [PosW-1:0] p);
      logic [PosW+15:0] wide;
      logic             big;
      wide = {16'd0, p};
      big  = |wide[PosW+15:16];
      return {big, (big ? SAT16 : wide[15:0])};
   endfunction

   // Selector registers
   select_type select_ff;

   // Input register
   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        in_last_ff;
   logic        in_empty_ff;

   // Record state
   logic [PosW-1:0] pos_ff,       pos_in;
   count_type       count_ff,     count_in;
   logic            entered_ff,   entered_in;
   logic [15:0]     seg_start_ff, seg_start_in;
   logic [15:0]     seg_length_ff, seg_length_in;
   logic            overflow_ff,  overflow_in;

   // Result register
   logic        rsp_valid_ff,  rsp_valid_in;
   logic [15:0] rsp_start_ff,  rsp_start_in;
   logic [15:0] rsp_length_ff, rsp_length_in;
   logic        rsp_flag_ff,   rsp_flag_in;

   logic        in_is_end;
   logic        advance;
   logic        match_now;
   logic        match_end;
   logic [1:0]  level;
   logic [16:0] pos_now_clip;
   logic [16:0] pos_end_clip;

   // Handshake: the input stage moves unless a record end meets a stalled result
   assign in_is_end = in_empty_ff | in_last_ff;
   assign advance   = !in_valid_ff || !(in_is_end && rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_match_start     = rsp_start_ff;
   assign rsp_match_length    = rsp_length_ff;
   assign rsp_record_too_long = rsp_flag_ff;

   mvfe_match u_match_now (
      .sel    (select_ff),
      .counts (count_ff),
      .hit    (match_now)
   );

   mvfe_match u_match_end (
      .sel    (select_ff),
      .counts (count_in),
      .hit    (match_end)
   );

   // Per-byte update of the record state
   always_comb begin
      level         = select_level(select_ff);
      pos_now_clip  = clip_pos(pos_ff);
      pos_in        = pos_ff;
      count_in      = count_ff;
      entered_in    = entered_ff;
      seg_start_in  = seg_start_ff;
      seg_length_in = seg_length_ff;
      overflow_in   = overflow_ff;
      if (!in_empty_ff) begin
         if (pos_ff >= PosLimit) begin
            overflow_in = 1'b1;
         end else begin
            // open the selected part at this byte
            if (!entered_ff && match_now) begin
               entered_in    = 1'b1;
               seg_start_in  = pos_now_clip[15:0];
               overflow_in   = overflow_in | pos_now_clip[16];
               seg_length_in = 16'd0;
            end
            // grow its length while inside it
            if (entered_in && match_now && !ends_segment(in_byte_ff, level)) begin
               if (seg_length_in == SAT16) begin
                  overflow_in = 1'b1;
               end else begin
                  seg_length_in = seg_length_in + 16'd1;
               end
            end
            // delimiter counts
            case (in_byte_ff)
               MARK_FIELD: begin
                  if (count_ff.field == SAT16) begin
                     overflow_in = 1'b1;
                  end else begin
                     count_in.field = count_ff.field + 16'd1;
                  end
                  count_in.value    = 16'd1;
                  count_in.subvalue = 16'd1;
               end
               MARK_VALUE: begin
                  if (count_ff.value == SAT16) begin
                     overflow_in = 1'b1;
                  end else begin
                     count_in.value = count_ff.value + 16'd1;
                  end
                  count_in.subvalue = 16'd1;
               end
               MARK_SUB: begin
                  if (count_ff.subvalue == SAT16) begin
                     overflow_in = 1'b1;
                  end else begin
                     count_in.subvalue = count_ff.subvalue + 16'd1;
                  end
               end
               default: begin
               end
            endcase
            pos_in = pos_ff + PosW'(1);
         end
      end
   end

   // Result at record end
   always_comb begin
      pos_end_clip  = clip_pos(pos_in);
      rsp_start_in  = 16'd0;
      rsp_length_in = 16'd0;
      rsp_flag_in   = overflow_in;
      if (select_negative(select_ff)) begin
         rsp_start_in  = 16'd0;
      end else if (select_whole(select_ff)) begin
         rsp_length_in = pos_end_clip[15:0];
         rsp_flag_in   = overflow_in | pos_end_clip[16];
      end else if (!entered_in && match_end) begin
         // part that starts at the record end: present but empty
         rsp_start_in  = pos_end_clip[15:0];
         rsp_flag_in   = overflow_in | pos_end_clip[16];
      end else if (entered_in) begin
         rsp_start_in  = seg_start_in;
         rsp_length_in = seg_length_in;
      end
   end

   always_comb begin
      if (in_valid_ff && in_is_end && advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control state and record state
   always_ff @(posedge clock) begin
      if (reset) begin
         select_ff     <= '0;
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         pos_ff        <= '0;
         count_ff      <= '{field: 16'd1, value: 16'd1, subvalue: 16'd1};
         entered_ff    <= 1'b0;
         seg_start_ff  <= 16'd0;
         seg_length_ff <= 16'd0;
         overflow_ff   <= 1'b0;
      end else begin
         // selector writes
         if (csr_write_enable) begin
            case (csr_index)
               CSR_FIELD_SELECT:    select_ff.field    <= $signed(csr_write_data);
               CSR_VALUE_SELECT:    select_ff.value    <= $signed(csr_write_data);
               CSR_SUBVALUE_SELECT: select_ff.subvalue <= $signed(csr_write_data);
               default: begin
               end
            endcase
         end
         if (advance) begin
            in_valid_ff <= req_valid;
         end
         rsp_valid_ff <= rsp_valid_in;
         if (in_valid_ff && advance) begin
            if (in_is_end) begin
               pos_ff        <= '0;
               count_ff      <= '{field: 16'd1, value: 16'd1, subvalue: 16'd1};
               entered_ff    <= 1'b0;
               seg_start_ff  <= 16'd0;
               seg_length_ff <= 16'd0;
               overflow_ff   <= 1'b0;
            end else begin
               pos_ff        <= pos_in;
               count_ff      <= count_in;
               entered_ff    <= entered_in;
               seg_start_ff  <= seg_start_in;
               seg_length_ff <= seg_length_in;
               overflow_ff   <= overflow_in;
            end
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (advance) begin
         in_byte_ff  <= req_data_byte;
         in_last_ff  <= req_last_byte;
         in_empty_ff <= req_empty_record;
      end
      if (in_valid_ff && in_is_end && advance) begin
         rsp_start_ff  <= rsp_start_in;
         rsp_length_ff <= rsp_length_in;
         rsp_flag_ff   <= rsp_flag_in;
      end
   end

endmodule

/* rtl/mvfe_match.sv */
// Compares the running field/value/subvalue counts with the selectors.
// Depends on mvfe_pkg.
module mvfe_match (
   input  mvfe_pkg::select_type sel,
   input  mvfe_pkg::count_type  counts,
   output logic                 hit
);
   import mvfe_pkg::*;

   logic [1:0]  level;
   logic [15:0] field_want;
   logic [15:0] value_want;

   // A zero selector above the selected level stands for number 1
   always_comb begin
      level      = select_level(sel);
      field_want = (sel.field == 16'sd0) ? 16'd1 : $unsigned(sel.field);
      value_want = (sel.value == 16'sd0) ? 16'd1 : $unsigned(sel.value);
      hit = !select_negative(sel) && !select_whole(sel) &&
            (counts.field == field_want) &&
            ((level == LEVEL_FIELD) || (counts.value == value_want)) &&
            ((level != LEVEL_SUB) || (counts.subvalue == $unsigned(sel.subvalue)));
   end

endmodule

/* rtl/mvfe_checker.sv */
// Port-level checks for the multivalue field extractor, bound to the top level.
// Depends on multivalue_field_extract.
module mvfe_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_match_start,
   input logic [15:0] rsp_match_length,
   input logic        rsp_record_too_long
);

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_match_start) &&
         $stable(rsp_match_length) && $stable(rsp_record_too_long))
      else $error("stalled result changed");

   // Requests are only held back by a stalled result
   a_req_free: assert property (@(posedge clock)
      !rsp_stall |-> !req_stall)
      else $error("request stalled while result side is free");

   // Reset empties both stages
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

   // A new result comes from a request stage that was moving
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_stall))
      else $error("result appeared while request stage was held");

endmodule

bind multivalue_field_extract mvfe_checker u_mvfe_checker (.*);
